FILE: rtl/jsu_pkg.sv
// ============================================================================
// jsu_pkg
// Shared types, constants and helper functions of the JSON string unescape
// unit: result kinds, the per-byte job record and the UTF-8 encoder.
// ============================================================================
package jsu_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_CLOSED  = 2'd1;
  localparam logic [1:0] KIND_NOQUOTE = 2'd2;
  localparam logic [1:0] KIND_UNTERM  = 2'd3;

  // Most results one source byte can cause.
  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Job queue between the decoder and the output serializer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Surrogate ranges and code point limits.
  localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
  localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [20:0] CP_ONE_MAX   = 21'h80;
  localparam logic [20:0] CP_TWO_MAX   = 21'h800;
  localparam logic [20:0] CP_THREE_MAX = 21'h10000;

  // Source characters of interest.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  // All results caused by one source byte.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [MAX_RESULTS-1:0][1:0] kinds;
    logic [RES_IDX_W-1:0]        last_idx;
  } job_t;

  // UTF-8 encoding of one code point.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [RES_CNT_W-1:0]        count;
  } utf8_t;

  // Value of one hex digit; anything else counts as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = 4'(b - 8'h37);
    end
    return v;
  endfunction

  // UTF-8 encoder for code points up to 21 bits.
  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp < CP_ONE_MAX) begin
      r.bytes[0] = cp[7:0];
      r.count    = RES_CNT_W'(1);
    end else if (cp < CP_TWO_MAX) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.count    = RES_CNT_W'(2);
    end else if (cp < CP_THREE_MAX) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.count    = RES_CNT_W'(3);
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.count    = RES_CNT_W'(4);
    end
    return r;
  endfunction

endpackage

FILE: rtl/jsu_front.sv
// ============================================================================
// jsu_front
// Decoder front end: accepts one source byte per cycle unless the queue is
// full, runs the string state machine and builds each byte's job of results.
// ============================================================================
module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  logic [7:0]    in_byte,
  input  logic          end_of_input,
  input  logic          queue_full,
  output logic          push,
  output jsu_pkg::job_t push_job
);

  typedef enum logic [6:0] {
    MODE_IDLE   = 7'b0000001,
    MODE_STR    = 7'b0000010,
    MODE_ESC    = 7'b0000100,
    MODE_HEX1   = 7'b0001000,
    MODE_HIGH   = 7'b0010000,
    MODE_HIGHBS = 7'b0100000,
    MODE_HEX2   = 7'b1000000
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] first_unit, first_unit_next;
  logic [15:0] second_unit, second_unit_next;
  logic [1:0]  digit_count, digit_count_next;

  logic        accept;
  logic [3:0]  hv;
  logic [15:0] unit_first, unit_second;
  logic [20:0] pair_cp, cp;
  logic        enc_en, tail_en;
  logic [7:0]  tail_byte, esc_byte;
  logic [1:0]  tail_kind;
  logic        is_ws;
  jsu_pkg::utf8_t enc;
  logic [jsu_pkg::RES_CNT_W-1:0] n_enc, total;

  assign byte_stall = queue_full;
  assign accept     = byte_valid && !queue_full;

  // Shared decode of the incoming byte.
  assign hv          = jsu_pkg::hex_value(in_byte);
  assign unit_first  = {first_unit[11:0], hv};
  assign unit_second = {second_unit[11:0], hv};
  assign pair_cp     = jsu_pkg::SUPP_BASE + {1'b0, first_unit[9:0], unit_second[9:0]};
  assign is_ws       = (in_byte == jsu_pkg::CH_SPACE) || (in_byte == jsu_pkg::CH_TAB) ||
                       (in_byte == jsu_pkg::CH_LF) || (in_byte == jsu_pkg::CH_CR);

  // Translation of a simple escape.
  always_comb begin
    case (in_byte)
      jsu_pkg::CH_B: esc_byte = jsu_pkg::CH_BS;
      jsu_pkg::CH_F: esc_byte = jsu_pkg::CH_FF;
      jsu_pkg::CH_N: esc_byte = jsu_pkg::CH_LF;
      jsu_pkg::CH_R: esc_byte = jsu_pkg::CH_CR;
      jsu_pkg::CH_T: esc_byte = jsu_pkg::CH_TAB;
      default:       esc_byte = in_byte;
    endcase
  end

  // String state machine. A byte may cause a UTF-8 sequence followed by one
  // trailing result (a plain byte, an escape or a status).
  always_comb begin
    mode_next        = mode;
    first_unit_next  = first_unit;
    second_unit_next = second_unit;
    digit_count_next = digit_count;
    cp               = {5'd0, first_unit};
    enc_en           = 1'b0;
    tail_en          = 1'b0;
    tail_byte        = 8'd0;
    tail_kind        = jsu_pkg::KIND_BYTE;
    if (end_of_input) begin
      tail_en   = 1'b1;
      tail_kind = (mode == MODE_IDLE) ? jsu_pkg::KIND_NOQUOTE : jsu_pkg::KIND_UNTERM;
      mode_next = MODE_IDLE;
    end else begin
      case (mode)
        MODE_STR, MODE_HIGH: begin
          if (mode == MODE_HIGH && in_byte == jsu_pkg::CH_BSLASH) begin
            mode_next = MODE_HIGHBS;
          end else begin
            // A held high surrogate with no second unit goes out alone.
            enc_en = (mode == MODE_HIGH);
            if (in_byte == jsu_pkg::CH_QUOTE) begin
              tail_en   = 1'b1;
              tail_kind = jsu_pkg::KIND_CLOSED;
              mode_next = MODE_IDLE;
            end else if (in_byte == jsu_pkg::CH_BSLASH) begin
              mode_next = MODE_ESC;
            end else begin
              tail_en   = 1'b1;
              tail_byte = in_byte;
              mode_next = MODE_STR;
            end
          end
        end
        MODE_ESC, MODE_HIGHBS: begin
          if (in_byte == jsu_pkg::CH_U) begin
            digit_count_next = 2'd0;
            if (mode == MODE_ESC) begin
              first_unit_next = 16'd0;
              mode_next       = MODE_HEX1;
            end else begin
              second_unit_next = 16'd0;
              mode_next        = MODE_HEX2;
            end
          end else begin
            enc_en    = (mode == MODE_HIGHBS);
            tail_en   = 1'b1;
            tail_byte = esc_byte;
            mode_next = MODE_STR;
          end
        end
        MODE_HEX1: begin
          first_unit_next  = unit_first;
          digit_count_next = digit_count + 2'd1;
          if (digit_count == 2'd3) begin
            if (unit_first >= jsu_pkg::HIGH_SURR_LO && unit_first <= jsu_pkg::HIGH_SURR_HI) begin
              mode_next = MODE_HIGH;
            end else begin
              enc_en    = 1'b1;
              cp        = {5'd0, unit_first};
              mode_next = MODE_STR;
            end
          end
        end
        MODE_HEX2: begin
          second_unit_next = unit_second;
          digit_count_next = digit_count + 2'd1;
          if (digit_count == 2'd3) begin
            enc_en    = 1'b1;
            mode_next = MODE_STR;
            if (unit_second >= jsu_pkg::LOW_SURR_LO && unit_second <= jsu_pkg::LOW_SURR_HI) begin
              cp = pair_cp;
            end
          end
        end
        default: begin
          // Idle: skip whitespace, await the opening quote, report other bytes.
          if (in_byte == jsu_pkg::CH_QUOTE) begin
            mode_next = MODE_STR;
          end else if (!is_ws) begin
            tail_en   = 1'b1;
            tail_kind = jsu_pkg::KIND_NOQUOTE;
            mode_next = MODE_IDLE;
          end
        end
      endcase
    end
  end

  // Assemble the job: encoded bytes first, then the trailing result.
  assign enc   = jsu_pkg::utf8_encode(cp);
  assign n_enc = enc_en ? enc.count : '0;
  assign total = n_enc + jsu_pkg::RES_CNT_W'(tail_en);

  always_comb begin
    for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
      if (jsu_pkg::RES_CNT_W'(i) < n_enc) begin
        push_job.bytes[i] = enc.bytes[i];
        push_job.kinds[i] = jsu_pkg::KIND_BYTE;
      end else begin
        push_job.bytes[i] = tail_byte;
        push_job.kinds[i] = tail_kind;
      end
    end
    push_job.last_idx = jsu_pkg::RES_IDX_W'(total - jsu_pkg::RES_CNT_W'(1));
  end

  assign push = accept && (total != '0);

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      first_unit  <= 16'd0;
      second_unit <= 16'd0;
      digit_count <= 2'd0;
    end else if (accept) begin
      mode        <= mode_next;
      first_unit  <= first_unit_next;
      second_unit <= second_unit_next;
      digit_count <= digit_count_next;
    end
  end

endmodule

FILE: rtl/jsu_queue.sv
// ============================================================================
// jsu_queue
// Small job queue that decouples the decoder from the output serializer.
// ============================================================================
module jsu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output jsu_pkg::job_t head
);

  jsu_pkg::job_t entries [jsu_pkg::QUEUE_DEPTH];
  logic [jsu_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [jsu_pkg::QCNT_W-1:0] count;

  assign full  = (count == jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + jsu_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + jsu_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + jsu_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - jsu_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/jsu_back.sv
// ============================================================================
// jsu_back
// Output serializer: walks the results of the head job one beat at a time
// into the result register.
// ============================================================================
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  jsu_pkg::job_t head,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_stall,
  output logic [7:0]    out_byte,
  output logic [1:0]    kind,
  output logic          last
);

  logic [jsu_pkg::RES_IDX_W-1:0] idx;
  logic load, at_last;

  // The result register takes a new beat when it is empty or being drained.
  assign load    = !empty && (!result_valid || !result_stall);
  assign at_last = (idx == head.last_idx);
  assign pop     = load && at_last;

  // Position inside the head job.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= at_last ? '0 : idx + jsu_pkg::RES_IDX_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.bytes[idx];
      kind     <= head.kinds[idx];
      last     <= at_last;
    end
  end

endmodule

FILE: rtl/json_string_unescape_utf8_unit.sv
// ============================================================================
// json_string_unescape_utf8_unit
// Decodes one JSON string literal at a time from a byte stream, translating
// escapes and emitting \u units as UTF-8.
//
//   Channel  Direction  Handshake                   Payload
//   source   in         byte_valid / byte_stall     in_byte, end_of_input
//   result   out        result_valid / result_stall out_byte, kind, last
//
// The decoder takes one source byte per cycle while its four-entry job queue
// has room. Each byte becomes a job of zero to four results; the serializer
// sends one beat per cycle while result_stall is low, one beat per result.
// A taken byte reaches the output through the job queue and result register.
// Reset (rst, synchronous) returns the decoder to idle and empties the queue.
// byte_stall rises only when the queue is full; result_stall holds the
// result register and, through the queue, backs up into the source side.
// ============================================================================
module json_string_unescape_utf8_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last
);

  logic          push, pop, full, empty;
  jsu_pkg::job_t push_job, head;

  // Decoder front end.
  jsu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .queue_full   (full),
    .push         (push),
    .push_job     (push_job)
  );

  // Job queue.
  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  // Output serializer.
  jsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .kind         (kind),
    .last         (last)
  );

endmodule

FILE: rtl/jsu_checker.sv
// ============================================================================
// jsu_checker
// Port-level checks of the JSON string unescape unit, bound to the top level.
// ============================================================================
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       byte_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] out_byte,
  input logic [1:0] kind,
  input logic       last
);

  // No result is offered right after reset.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered after reset");

  // The source side has room right after reset.
  assert property (@(posedge clk) rst |=> !byte_stall)
    else $error("source stalled after reset");

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(out_byte) &&
    $stable(kind) && $stable(last))
    else $error("stalled result changed");

  // Status results carry no byte and always end their group.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind != jsu_pkg::KIND_BYTE) |-> last && (out_byte == 8'd0))
    else $error("status result malformed");

  // A group that is not finished continues in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !last |=> result_valid)
    else $error("result group broken off");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_stall   (byte_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .out_byte     (out_byte),
  .kind         (kind),
  .last         (last)
);
